// File: sv/scs_pkg.sv
// Package for the sequence command scanner: scan phase type, command byte
// constants, the result word type and the command length table.
// Depends on nothing; imported by the scanner and its checker.
`timescale 1ns / 1ps

package scs_pkg;

   // Field widths of the input and result words.
   localparam int ByteW  = 8;
   localparam int TrackW = 5;
   localparam int SkipW  = 3;
   localparam int LenW   = 2;

   // Command byte codes.
   localparam logic [ByteW-1:0] CMD_EXT_LO   = 8'he0;
   localparam logic [ByteW-1:0] CMD_EXT_HI   = 8'he6;
   localparam logic [ByteW-1:0] CMD_NOTE_LO  = 8'h80;
   localparam logic [ByteW-1:0] CMD_NOTE_HI  = 8'hdf;
   localparam logic [ByteW-1:0] CMD_SEL7     = 8'he7;
   localparam logic [ByteW-1:0] CMD_SELA_LO  = 8'hea;
   localparam logic [ByteW-1:0] CMD_SELA_HI  = 8'hec;
   localparam logic [ByteW-1:0] CMD_END      = 8'hf1;
   localparam logic [ByteW-1:0] CMD_TWO_LO   = 8'he9;
   localparam logic [ByteW-1:0] CMD_LONG_ONE = 8'hfe;
   localparam logic [ByteW-1:0] SEL7_LONG    = 8'h01;
   localparam logic [ByteW-1:0] EXT_NONE     = 8'h00;

   // Operand counts chosen by the selector byte of 0xea-0xec.
   localparam logic [SkipW-1:0] SELA_SHORT_SKIP = 3'd0;
   localparam logic [SkipW-1:0] SELA_LONG_SKIP  = 3'd4;

   // Event kinds.
   localparam logic EVT_EXT = 1'b0;
   localparam logic EVT_END = 1'b1;

   // Scan phases.
   typedef enum logic [2:0] {
      PH_STOP = 3'd0,
      PH_CMD  = 3'd1,
      PH_SEL7 = 3'd2,
      PH_SELA = 3'd3,
      PH_SKIP = 3'd4
   } scan_phase_type;

   // One result word.
   typedef struct packed {
      logic              event_kind;
      logic [TrackW-1:0] track_id;
      logic [ByteW-1:0]  ext_command;
   } result_type;

   // Total length in bytes of a command with a fixed length.
   function automatic logic [LenW-1:0] fixed_length(input logic [ByteW-1:0] b);
      logic [LenW-1:0] len;
      if (b < CMD_NOTE_LO) begin
         len = 2'd1;
      end else if (b <= CMD_NOTE_HI) begin
         len = 2'd2;
      end else begin
         case (b)
            8'he8, 8'hee, 8'hf7, 8'hf9, 8'hfa: len = 2'd1;
            CMD_END, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6, CMD_LONG_ONE: len = 2'd3;
            default: len = (b >= CMD_TWO_LO) ? 2'd2 : 2'd1;
         endcase
      end
      return len;
   endfunction

endpackage

// File: sv/sequence_command_scanner.sv
// Sequence command scanner: walks the command bytes of a track and reports
// the first extension command or the end of the track scan.
// Depends on scs_pkg.
`timescale 1ns / 1ps

// Usage:
// The req channel carries one byte word per accepted transfer, together with
// a track start flag, a track number and a last-byte flag. The rsp channel
// returns at most one event word per byte: an extension event with the
// command byte, or an end event when the track ends, is cut short by the
// buffer end or runs into a 0xf1 end command.
// Throughput is one byte word per cycle while req_stall is low. The scan
// state is updated in the cycle a byte is accepted. Its event word goes to
// the rsp output register, or to a one-word skid register behind it, so a
// byte is still taken while an event waits on a stalled receiver; req_stall
// rises only once both registers hold words, and falls the cycle after the
// receiver takes one.
// Reset (synchronous) stops the scan, clears the track number and empties
// both result registers. Bytes seen while the scan is stopped are dropped
// until a byte with track_start arrives.
module sequence_command_scanner #(
   parameter int MAX_TRACKS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [scs_pkg::ByteW-1:0]  req_data_byte,
   input  logic                      req_track_start,
   input  logic [scs_pkg::TrackW-1:0] req_track_index,
   input  logic                      req_data_last,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_event_kind,
   output logic [scs_pkg::TrackW-1:0] rsp_track_id,
   output logic [scs_pkg::ByteW-1:0]  rsp_ext_command
);
   import scs_pkg::*;

   scan_phase_type    phase_ff, phase_in, eff_phase;
   logic [SkipW-1:0]  skip_ff, skip_in, eff_skip, skip_dec;
   logic [TrackW-1:0] track_ff, track_in, eff_track;
   logic              pend_ff, pend_in, eff_pend;

   logic              accept;
   logic              start_ok;
   logic              is_ext;
   logic              hit_ext, hit_f1end, hit_last, emit;
   logic [LenW-1:0]   cmd_len;
   result_type        res;

   result_type        rsp_ff, skid_ff;
   logic              rsp_valid_ff, skid_valid_ff;
   logic              rsp_take;

   assign accept   = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   // A track start resets the scan state before the byte is decoded.
   assign start_ok  = req_track_start && (32'(req_track_index) < MAX_TRACKS);
   assign eff_track = start_ok ? req_track_index : track_ff;
   assign eff_skip  = req_track_start ? '0 : skip_ff;
   assign eff_pend  = req_track_start ? 1'b0 : pend_ff;
   always_comb begin
      if (req_track_start) begin
         eff_phase = start_ok ? PH_CMD : PH_STOP;
      end else begin
         eff_phase = phase_ff;
      end
   end

   // Byte decode used by the next-state and event logic.
   assign is_ext   = (req_data_byte >= CMD_EXT_LO) && (req_data_byte <= CMD_EXT_HI);
   assign cmd_len  = fixed_length(req_data_byte);
   assign skip_dec = (eff_skip == '0) ? '0 : eff_skip - 1'b1;

   // Event decision for the current byte.
   always_comb begin
      hit_ext   = (eff_phase == PH_CMD) && is_ext;
      hit_f1end = (eff_phase == PH_SKIP) && (skip_dec == '0) && eff_pend;
      hit_last  = req_data_last && (eff_phase != PH_STOP) && !hit_ext && !hit_f1end;
      emit      = hit_ext || hit_f1end || hit_last;
      res.event_kind  = hit_ext ? EVT_EXT : EVT_END;
      res.track_id    = eff_track;
      res.ext_command = hit_ext ? req_data_byte : EXT_NONE;
   end

   // Next scan state.
   always_comb begin
      phase_in = eff_phase;
      skip_in  = eff_skip;
      pend_in  = eff_pend;
      track_in = eff_track;
      unique case (eff_phase)
         PH_CMD: begin
            if (req_data_byte == CMD_SEL7) begin
               phase_in = PH_SEL7;
            end else if ((req_data_byte >= CMD_SELA_LO) &&
                         (req_data_byte <= CMD_SELA_HI)) begin
               phase_in = PH_SELA;
            end else if (cmd_len > 2'd1) begin
               skip_in  = SkipW'(cmd_len - 2'd1);
               phase_in = PH_SKIP;
            end
            if (req_data_byte == CMD_END) begin
               pend_in = 1'b1;
            end
         end
         PH_SEL7: begin
            skip_in  = (req_data_byte == SEL7_LONG) ? 3'd1 : 3'd0;
            phase_in = (req_data_byte == SEL7_LONG) ? PH_SKIP : PH_CMD;
         end
         PH_SELA: begin
            skip_in  = req_data_byte[ByteW-1] ? SELA_SHORT_SKIP : SELA_LONG_SKIP;
            phase_in = req_data_byte[ByteW-1] ? PH_CMD : PH_SKIP;
         end
         PH_SKIP: begin
            skip_in  = skip_dec;
            if (skip_dec == '0) begin
               phase_in = PH_CMD;
            end
         end
         default: begin
            phase_in = PH_STOP;
         end
      endcase
      // Any event stops the scan.
      if (emit) begin
         phase_in = PH_STOP;
         skip_in  = '0;
         pend_in  = 1'b0;
      end
   end

   // Scan state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_STOP;
         skip_ff  <= '0;
         track_ff <= '0;
         pend_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
         track_ff <= track_in;
         pend_ff  <= pend_in;
      end
   end

   // Output register with a one-word skid register behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept && emit) begin
            if (rsp_valid_ff && !rsp_take) begin
               skid_valid_ff <= 1'b1;
            end else begin
               rsp_valid_ff <= 1'b1;
            end
         end else if (rsp_take) begin
            rsp_valid_ff  <= skid_valid_ff;
            skid_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         if (rsp_valid_ff && !rsp_take) begin
            skid_ff <= res;
         end else begin
            rsp_ff <= res;
         end
      end else if (rsp_take && skid_valid_ff) begin
         rsp_ff <= skid_ff;
      end
   end

   assign req_stall       = skid_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = rsp_ff.event_kind;
   assign rsp_track_id    = rsp_ff.track_id;
   assign rsp_ext_command = rsp_ff.ext_command;

endmodule

// File: sv/scs_checker.sv
// Port-level checker for the sequence command scanner, bound into the scanner module.
// Depends on scs_pkg and sequence_command_scanner.
`timescale 1ns / 1ps

module scs_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic                       rsp_event_kind,
   input logic [scs_pkg::TrackW-1:0] rsp_track_id,
   input logic [scs_pkg::ByteW-1:0]  rsp_ext_command
);
   import scs_pkg::*;

   // After reset the result side is empty.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present after reset");

   // The input side only stalls while a result word is waiting.
   a_stall_backed: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result word pending");

   // An extension event carries a command byte from the extension range.
   a_ext_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind == EVT_EXT) |->
         (rsp_ext_command >= CMD_EXT_LO && rsp_ext_command <= CMD_EXT_HI))
      else $error("extension event with a command byte out of range");

   // An end event carries no command byte.
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind == EVT_END) |-> (rsp_ext_command == EXT_NONE))
      else $error("end event with a nonzero command byte");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_event_kind) && $stable(rsp_track_id) &&
          $stable(rsp_ext_command)))
      else $error("stalled result word changed");

endmodule

bind sequence_command_scanner scs_checker u_scs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_event_kind  (rsp_event_kind),
   .rsp_track_id    (rsp_track_id),
   .rsp_ext_command (rsp_ext_command)
);
